// File: hw/rtl/edud_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edud_pkg
// Shared types, constants and helpers of the 2x edge-directed dither upscaler.
// ----------------------------------------------------------------------------
package edud_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgEdgeDecay     = 2'd0;
  localparam logic [1:0] CfgEdgeThreshold = 2'd1;
  localparam logic [1:0] CfgFrameNumber   = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  EdgeDecayRst     = 8'd4;
  localparam logic [7:0]  EdgeThresholdRst = 8'd28;
  localparam logic [63:0] FrameNumberRst   = 64'd0;

  // Dither matrix seed: M = SeedBase ^ (frame * SeedMul) mod 2^64
  localparam logic [63:0] SeedBase = 64'h1B84_2091_0A4C_2E01;
  localparam logic [63:0] SeedMul  = 64'h9E37_79B9_7F4A_7C15;

  // Spin key for the pixel-wide diagonal vote
  localparam logic [31:0] SpinKey = 32'h0101_0101;

  // Two parity rows of the dither matrix (bytes 7 and 6)
  typedef struct packed {
    logic [7:0] row0;
    logic [7:0] row1;
  } dith_rows_t;

  // Rounded-up average of two channels
  function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

  // Absolute difference of two channels
  function automatic logic [7:0] adiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/edud_seed.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edud_seed
// Two-stage computation of the dither matrix rows from the frame number.
// The 64x64 product mod 2^64 is split into three 32x32 partial products.
// ----------------------------------------------------------------------------
module edud_seed (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [63:0]          frame_i,
  output edud_pkg::dith_rows_t      rows_o
);

  localparam logic [31:0] MulLo = edud_pkg::SeedMul[31:0];
  localparam logic [31:0] MulHi = edud_pkg::SeedMul[63:32];

  logic [63:0] prod_ll_d, prod_ll_q;
  logic [63:0] prod_hl_full, prod_lh_full;
  logic [31:0] prod_x_d, prod_x_q;
  logic [63:0] sum;
  logic [63:0] mat;
  edud_pkg::dith_rows_t rows_d, rows_q;

  // Stage 1: partial products (cross terms only need their low halves)
  always_comb begin
    prod_ll_d    = {32'd0, frame_i[31:0]} * {32'd0, MulLo};
    prod_hl_full = {32'd0, frame_i[63:32]} * {32'd0, MulLo};
    prod_lh_full = {32'd0, frame_i[31:0]} * {32'd0, MulHi};
    prod_x_d     = prod_hl_full[31:0] + prod_lh_full[31:0];
  end

  // Stage 2: combine, mix with base seed, keep the two parity rows
  always_comb begin
    sum         = prod_ll_q + {prod_x_q, 32'd0};
    mat         = edud_pkg::SeedBase ^ sum;
    rows_d.row0 = mat[63:56];
    rows_d.row1 = mat[55:48];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_ll_q   <= 64'd0;
      prod_x_q    <= 32'd0;
      rows_q.row0 <= edud_pkg::SeedBase[63:56];
      rows_q.row1 <= edud_pkg::SeedBase[55:48];
    end else begin
      prod_ll_q <= prod_ll_d;
      prod_x_q  <= prod_x_d;
      rows_q    <= rows_d;
    end
  end

  assign rows_o = rows_q;

endmodule
`default_nettype wire

// File: hw/rtl/edge_directed_dither_upscale_2x_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edge_directed_dither_upscale_2x_top
// 2x upscaler: one 2x2 source window in, one 2x2 output block out.
//
//   Channel   Ports                                   Transfer when
//   --------  --------------------------------------  -------------------------
//   input     top_left_i .. at_bottom_edge_i          start high, busy low
//   result    out_top_left_o .. out_bottom_right_o    out_valid_o high
//   config    cfg_we_i, cfg_idx_i, cfg_data_i         cfg_we_i high
//
// One window per cycle; each result passes through the three register stages
// (clamp, window terms, diagonal/dither).
// busy is always low. Results cannot be held off by the receiver.
// Reset loads the registers with their defaults and clears the pipeline.
// A frame_number write reaches the dither rows through a two-stage multiply,
// in time for a window started at the same or any later edge.
// ----------------------------------------------------------------------------
module edge_directed_dither_upscale_2x_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input window
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] top_left_i,
  input  wire logic [31:0] top_right_i,
  input  wire logic [31:0] bottom_left_i,
  input  wire logic [31:0] bottom_right_i,
  input  wire logic        at_right_edge_i,
  input  wire logic        at_bottom_edge_i,
  // result block
  output logic             out_valid_o,
  output logic [31:0]      out_top_left_o,
  output logic [31:0]      out_top_right_o,
  output logic [31:0]      out_bottom_left_o,
  output logic [31:0]      out_bottom_right_o,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i
);

  // Population count of a 32-bit word
  function automatic logic [5:0] pop32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 32; i++) begin
      n = n + {5'd0, v[i]};
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  edge_decay_d, edge_decay_q;
  logic [7:0]  edge_threshold_d, edge_threshold_q;
  logic [63:0] frame_number_d, frame_number_q;

  always_comb begin
    edge_decay_d     = edge_decay_q;
    edge_threshold_d = edge_threshold_q;
    frame_number_d   = frame_number_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        edud_pkg::CfgEdgeDecay:     edge_decay_d     = cfg_data_i[7:0];
        edud_pkg::CfgEdgeThreshold: edge_threshold_d = cfg_data_i[7:0];
        edud_pkg::CfgFrameNumber:   frame_number_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_decay_q     <= edud_pkg::EdgeDecayRst;
      edge_threshold_q <= edud_pkg::EdgeThresholdRst;
      frame_number_q   <= edud_pkg::FrameNumberRst;
    end else begin
      edge_decay_q     <= edge_decay_d;
      edge_threshold_q <= edge_threshold_d;
      frame_number_q   <= frame_number_d;
    end
  end

  // Dither rows follow the next frame value so a same-edge start sees it
  edud_pkg::dith_rows_t rows;

  edud_seed u_seed (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .frame_i(frame_number_d),
    .rows_o (rows)
  );

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: clamp neighbours at the frame edges
  // --------------------------------------------------------------------------
  logic        s1_valid_q;
  logic [31:0] s1_a_q, s1_b_q, s1_c_q, s1_d_q;
  logic [31:0] cl_b, cl_c, cl_d, row_c, row_d;

  always_comb begin
    row_c = at_bottom_edge_i ? top_left_i  : bottom_left_i;
    row_d = at_bottom_edge_i ? top_right_i : bottom_right_i;
    cl_c  = row_c;
    cl_b  = at_right_edge_i ? top_left_i : top_right_i;
    cl_d  = at_right_edge_i ? row_c      : row_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_a_q <= top_left_i;
    s1_b_q <= cl_b;
    s1_c_q <= cl_c;
    s1_d_q <= cl_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: averages, gradient sum, diagonal choices
  // --------------------------------------------------------------------------
  logic                 s2_valid_q;
  logic [31:0]          s2_a_q;
  logic [3:0][7:0]      avg_ab_d, avg_ac_d, avg_cd_d, gsat_d, phys_d, ising_d;
  logic [3:0][7:0]      s2_avg_ab_q, s2_avg_ac_q, s2_avg_cd_q;
  logic [3:0][7:0]      s2_gsat_q, s2_phys_q, s2_ising_q;
  logic                 vote_bc;

  always_comb begin
    logic [7:0] pa, pb, pc, pd, avg_ad, avg_bc;
    logic [8:0] gsum;
    vote_bc = pop32(s1_d_q ^ edud_pkg::SpinKey) < pop32(s1_c_q ^ edud_pkg::SpinKey);
    for (int k = 0; k < 4; k++) begin
      pa = s1_a_q[8*k +: 8];
      pb = s1_b_q[8*k +: 8];
      pc = s1_c_q[8*k +: 8];
      pd = s1_d_q[8*k +: 8];
      avg_ab_d[k] = edud_pkg::avg8(pa, pb);
      avg_ac_d[k] = edud_pkg::avg8(pa, pc);
      avg_cd_d[k] = edud_pkg::avg8(pc, pd);
      avg_ad      = edud_pkg::avg8(pa, pd);
      avg_bc      = edud_pkg::avg8(pb, pc);
      gsum        = {1'b0, edud_pkg::adiff(pa, pb)} + {1'b0, edud_pkg::adiff(pa, pc)};
      gsat_d[k]   = gsum[8] ? 8'hFF : gsum[7:0];
      phys_d[k]   = (edud_pkg::adiff(pa, pd) < edud_pkg::adiff(pb, pc)) ? avg_ad : avg_bc;
      ising_d[k]  = vote_bc ? avg_bc : avg_ad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_a_q      <= s1_a_q;
    s2_avg_ab_q <= avg_ab_d;
    s2_avg_ac_q <= avg_ac_d;
    s2_avg_cd_q <= avg_cd_d;
    s2_gsat_q   <= gsat_d;
    s2_phys_q   <= phys_d;
    s2_ising_q  <= ising_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: smoothed mean or dithered edge-directed diagonal
  // --------------------------------------------------------------------------
  logic            s3_valid_q;
  logic [31:0]     s3_tl_q, s3_tr_q, s3_bl_q, s3_br_q;
  logic [3:0][7:0] diag_d;

  always_comb begin
    logic [7:0] base, grad, e, r1;
    logic [8:0] up;
    logic       n0, n1;
    for (int k = 0; k < 4; k++) begin
      base = edud_pkg::avg8(s2_avg_ab_q[k], s2_avg_cd_q[k]);
      grad = (s2_gsat_q[k] > edge_decay_q) ? (s2_gsat_q[k] - edge_decay_q) : 8'd0;
      e    = edud_pkg::avg8(s2_phys_q[k], s2_ising_q[k]);
      n0   = ^(e & rows.row0);
      n1   = ^(e & rows.row1);
      up   = {1'b0, e} + {8'd0, n0};
      r1   = up[8] ? 8'hFF : up[7:0];
      r1   = (r1 >= {7'd0, n1}) ? (r1 - {7'd0, n1}) : 8'd0;
      diag_d[k] = (grad > edge_threshold_q) ? r1 : base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_tl_q <= s2_a_q;
    s3_tr_q <= s2_avg_ab_q;
    s3_bl_q <= s2_avg_ac_q;
    s3_br_q <= diag_d;
  end

  // Result ports
  assign out_valid_o        = s3_valid_q;
  assign out_top_left_o     = s3_tl_q;
  assign out_top_right_o    = s3_tr_q;
  assign out_bottom_left_o  = s3_bl_q;
  assign out_bottom_right_o = s3_br_q;

endmodule
`default_nettype wire
